// ===== rtl/uepd_pkg.sv =====
// Shared types, codes and defaults for the ultrasonic echo presence detector.
package uepd_pkg;

    // Default counter width for the tick counter
    localparam int COUNT_BITS_DEF = 16;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_WAIT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 2'd2;

    // Configuration reset values
    localparam logic [7:0]  TRIGGER_WIDTH_RST = 8'd10;
    localparam logic [15:0] ECHO_WAIT_RST     = 16'd2500;
    localparam logic [15:0] THRESHOLD_RST     = 16'd1166;

    // Outcome codes
    localparam logic [1:0] OUT_NO_ECHO = 2'd0;
    localparam logic [1:0] OUT_ABSENT  = 2'd1;
    localparam logic [1:0] OUT_PRESENT = 2'd2;

    // Measurement phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TRIG = 2'd1,
        PH_WAIT = 2'd2,
        PH_MEAS = 2'd3
    } phase_t;

    // Input word: one microsecond tick
    typedef struct packed {
        logic start_request;
        logic echo_level;
    } in_word_t;

    // Result word for that tick
    typedef struct packed {
        logic       trigger_level;
        logic       done_res;
        logic [1:0] outcome;
    } out_word_t;

    // Live configuration handed to the sequencer
    typedef struct packed {
        logic [7:0]  trigger_width_us;
        logic [15:0] echo_wait_limit_us;
        logic [15:0] presence_threshold_us;
    } cfg_t;

endpackage

// ===== rtl/ultrasonic_echo_presence_detector_unit.sv =====
// Top level of the ultrasonic echo presence detector: config, handshake, result register.
//
//  channel | direction | handshake                  | word
//  --------+-----------+----------------------------+--------------------------------
//  in      | input     | in_valid / in_ready        | in_data  (start_request, echo)
//  out     | output    | out_valid / out_ready      | out_data (trigger, done, outcome)
//  cfg     | input     | cfg_we, cfg_index          | cfg_data (16 bits, no read-back)
//
// One word per cycle while the output is not stalled: a tick is decoded combinationally
// against the phase and counter registers and its result is registered on acceptance.
// The input is taken whenever the output register is empty or being drained.
// Reset returns the phase to idle, clears the counter and loads default settings.
// A stalled output holds its word and stops intake until it is taken.
module ultrasonic_echo_presence_detector_unit #(
    parameter int COUNT_BITS = uepd_pkg::COUNT_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  uepd_pkg::in_word_t                 in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output uepd_pkg::out_word_t                out_data,
    input  logic                               cfg_we,
    input  logic [uepd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [uepd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import uepd_pkg::*;

    cfg_t      cfg_reg;
    out_word_t res_word;
    out_word_t out_data_reg;
    logic      out_valid_reg;
    logic      in_accept;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_width_us      <= TRIGGER_WIDTH_RST;
            cfg_reg.echo_wait_limit_us    <= ECHO_WAIT_RST;
            cfg_reg.presence_threshold_us <= THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TRIGGER_WIDTH: cfg_reg.trigger_width_us      <= cfg_data[7:0];
                CFG_ECHO_WAIT:     cfg_reg.echo_wait_limit_us    <= cfg_data;
                CFG_THRESHOLD:     cfg_reg.presence_threshold_us <= cfg_data;
                default:           cfg_reg                       <= cfg_reg;
            endcase
        end
    end

    // Intake runs whenever the result register can take a word
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    uepd_seq #(
        .COUNT_BITS (COUNT_BITS)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (in_accept),
        .in_word  (in_data),
        .cfg      (cfg_reg),
        .res_word (res_word)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg <= res_word;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/uepd_seq.sv =====
// Phase sequencer and saturating tick counter: one tick per step.
module uepd_seq #(
    parameter int COUNT_BITS = uepd_pkg::COUNT_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  uepd_pkg::in_word_t  in_word,
    input  uepd_pkg::cfg_t      cfg,
    output uepd_pkg::out_word_t res_word
);
    import uepd_pkg::*;

    localparam int XW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    phase_t                phase_reg, phase_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;

    logic [COUNT_BITS-1:0] cnt_inc;
    logic [15:0]           limit;
    logic                  hit;
    logic                  trig_short;
    logic                  thr_zero;

    // Saturating increment and limit compare for the active phase
    assign cnt_inc = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + CNT_ONE;

    always_comb
    begin
        unique case (phase_reg)
            PH_TRIG: limit = {8'd0, cfg.trigger_width_us};
            PH_WAIT: limit = cfg.echo_wait_limit_us;
            default: limit = cfg.presence_threshold_us;
        endcase
    end

    assign hit        = (XW'(cnt_inc) >= XW'(limit)) || (cnt_inc == CNT_MAX);
    // widths of zero or one finish the trigger on the start tick
    assign trig_short = (cfg.trigger_width_us <= 8'd1);
    assign thr_zero   = (cfg.presence_threshold_us == 16'd0);

    // Next phase and counter
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (in_word.start_request)
                begin
                    if (trig_short)
                    begin
                        phase_next = PH_WAIT;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        phase_next = PH_TRIG;
                        cnt_next   = CNT_ONE;
                    end
                end
            end
            PH_TRIG:
            begin
                cnt_next = cnt_inc;
                if (hit)
                begin
                    phase_next = PH_WAIT;
                    cnt_next   = '0;
                end
            end
            PH_WAIT:
            begin
                if (in_word.echo_level)
                begin
                    cnt_next   = '0;
                    phase_next = thr_zero ? PH_IDLE : PH_MEAS;
                end
                else
                begin
                    cnt_next = cnt_inc;
                    if (hit)
                    begin
                        phase_next = PH_IDLE;
                        cnt_next   = '0;
                    end
                end
            end
            PH_MEAS:
            begin
                if (!in_word.echo_level)
                begin
                    phase_next = PH_IDLE;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_inc;
                    if (hit)
                    begin
                        phase_next = PH_IDLE;
                        cnt_next   = '0;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    // Result for this tick
    always_comb
    begin
        res_word = '0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                res_word.trigger_level = in_word.start_request;
            end
            PH_TRIG:
            begin
                res_word.trigger_level = 1'b1;
            end
            PH_WAIT:
            begin
                if (in_word.echo_level)
                begin
                    if (thr_zero)
                    begin
                        res_word.done_res = 1'b1;
                        res_word.outcome  = OUT_ABSENT;
                    end
                end
                else if (hit)
                begin
                    res_word.done_res = 1'b1;
                    res_word.outcome  = OUT_NO_ECHO;
                end
            end
            PH_MEAS:
            begin
                if (!in_word.echo_level)
                begin
                    res_word.done_res = 1'b1;
                    res_word.outcome  = OUT_PRESENT;
                end
                else if (hit)
                begin
                    res_word.done_res = 1'b1;
                    res_word.outcome  = OUT_ABSENT;
                end
            end
            default:
            begin
                res_word = '0;
            end
        endcase
    end

    // State registers advance once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule
